[rtl/tcpr_pkg.sv]
package tcpr_pkg;

    // Window geometry and field widths.
    localparam int unsigned WINDOW_SIZE = 64;
    localparam int unsigned SLOT_W      = $clog2(WINDOW_SIZE);
    localparam int unsigned POS_W       = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PEND_W      = 7;
    localparam int unsigned CMD_W       = 2;

    // Command queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [PEND_W-1:0] t_pend;

    // Input command codes; the reserved code behaves as a plain data byte.
    typedef enum logic [CMD_W-1:0] {
        CMD_DATA     = 2'd0,
        CMD_DATA_END = 2'd1,
        CMD_END      = 2'd2,
        CMD_RSVD     = 2'd3
    } t_command;

    // One decoded item as it waits in the queue.
    typedef struct packed {
        logic  has_data;
        logic  sets_end;
        t_pos  index;
        t_pos  end_pos;
        t_byte byte_value;
    } t_cmd_entry;

    // Head of the queue as the back sees it.
    typedef struct packed {
        logic       valid;
        t_cmd_entry entry;
    } t_q_head;

    // Ring slot addition, modulo the window size; both operands are below it.
    function automatic t_slot f_slot_add(t_slot a, t_slot b);
        logic [SLOT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (SLOT_W + 1)'(WINDOW_SIZE)) begin
            sum = sum - (SLOT_W + 1)'(WINDOW_SIZE);
        end
        return sum[SLOT_W-1:0];
    endfunction

endpackage

[rtl/tcpr_stream_if.sv]
// Input channel: one stream byte or end marker per item.
interface tcpr_in_if import tcpr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [POS_W-1:0]     stream_index;
    logic [BYTE_W-1:0]    byte_value;

    modport source(output valid, command, stream_index, byte_value, input ready);
    modport sink(input valid, command, stream_index, byte_value, output ready);
endinterface

// Output channel: one assembled byte or status per item.
interface tcpr_out_if import tcpr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 has_byte;
    logic [BYTE_W-1:0]    out_byte;
    logic [POS_W-1:0]     out_position;
    logic [PEND_W-1:0]    pending_count;
    logic                 stream_ended;
    logic                 last_of_run;

    modport source(output valid, has_byte, out_byte, out_position, pending_count,
                   stream_ended, last_of_run, input ready);
    modport sink(input valid, has_byte, out_byte, out_position, pending_count,
                 stream_ended, last_of_run, output ready);
endinterface

[rtl/tcpr_ram.sv]
module tcpr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/tcpr_front.sv]
module tcpr_front import tcpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcpr_in_if.sink    i_in,
    input  logic       i_pop,
    output t_q_head    o_q
);

    t_cmd_entry          r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QCNT_W-1:0]   n_count;
    t_cmd_entry          dec_entry;
    logic                push;
    logic                pop;

    // Decode the command into what the back has to do with the item.
    always_comb begin
        dec_entry.index      = i_in.stream_index;
        dec_entry.byte_value = i_in.byte_value;
        unique case (t_command'(i_in.command))
            CMD_END: begin
                dec_entry.has_data = 1'b0;
                dec_entry.sets_end = 1'b1;
                dec_entry.end_pos  = i_in.stream_index;
            end
            CMD_DATA_END: begin
                dec_entry.has_data = 1'b1;
                dec_entry.sets_end = 1'b1;
                dec_entry.end_pos  = i_in.stream_index + POS_W'(1);
            end
            default: begin
                dec_entry.has_data = 1'b1;
                dec_entry.sets_end = 1'b0;
                dec_entry.end_pos  = i_in.stream_index + POS_W'(1);
            end
        endcase
    end

    assign i_in.ready = (r_count < QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in.valid & i_in.ready;
    assign pop        = i_pop & (r_count != '0);

    // Queue pointers advance with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entries[r_wr_ptr] <= dec_entry;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.entry = r_entries[r_rd_ptr];

    // The occupancy never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    // The back only pops a queue that holds an item.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty command queue");

endmodule

[rtl/tcpr_back.sv]
module tcpr_back import tcpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_head     i_q,
    output logic        o_pop,
    tcpr_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [WINDOW_SIZE-1:0] r_valid, n_valid;
    t_pos                   r_head, n_head;
    t_slot                  r_head_slot, n_head_slot;
    t_pend                  r_pending, n_pending;
    logic                   r_end_known, n_end_known;
    t_pos                   r_end, n_end;

    logic                   r_out_valid, n_out_valid;
    logic                   r_has_byte, n_has_byte;
    t_byte                  r_out_byte, n_out_byte;
    t_pos                   r_out_pos, n_out_pos;
    t_pend                  r_out_pend, n_out_pend;
    logic                   r_out_ended, n_out_ended;
    logic                   r_out_last, n_out_last;

    t_cmd_entry             ent;
    t_pos                   off;
    t_pos                   end_diff;
    t_pos                   head_inc;
    t_pos                   head_end_diff;
    t_pos                   inc_end_diff;
    t_slot                  wr_slot;
    t_slot                  next_slot;
    logic                   in_win;
    logic                   behind;
    logic                   past_end;
    logic                   do_store;
    logic                   at_end;
    logic                   deliverable;
    logic                   more;
    logic                   out_free;
    logic                   rd_en;
    t_byte                  rd_data;

    // Window position of the queued item relative to the head.
    assign ent           = i_q.entry;
    assign off           = ent.index - r_head;
    assign end_diff      = ent.index - r_end;
    assign in_win        = (off < POS_W'(WINDOW_SIZE));
    assign behind        = off[POS_W-1];
    assign past_end      = r_end_known & ~end_diff[POS_W-1];
    assign wr_slot       = f_slot_add(r_head_slot, off[SLOT_W-1:0]);
    assign do_store      = (r_state == S_IDLE) & i_q.valid & ent.has_data & in_win
                         & ~past_end & ~r_valid[wr_slot];

    // Drain conditions at the head.
    assign head_inc      = r_head + POS_W'(1);
    assign head_end_diff = r_head - r_end;
    assign inc_end_diff  = head_inc - r_end;
    assign next_slot     = f_slot_add(r_head_slot, SLOT_W'(1));
    assign at_end        = r_end_known & (r_head == r_end);
    assign deliverable   = r_valid[r_head_slot] & ~at_end;
    assign more          = r_valid[next_slot] & ~(r_end_known & (head_inc == r_end));
    assign out_free      = ~r_out_valid | o_out.ready;
    assign rd_en         = (r_state == S_CHECK) & deliverable;
    assign o_pop         = (r_state == S_IDLE) & i_q.valid;

    tcpr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(WINDOW_SIZE)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (do_store),
        .i_wr_addr (wr_slot),
        .i_wr_data (ent.byte_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head_slot),
        .o_rd_data (rd_data)
    );

    // Store, end latch and drain sequencing.
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_head      = r_head;
        n_head_slot = r_head_slot;
        n_pending   = r_pending;
        n_end_known = r_end_known;
        n_end       = r_end;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_has_byte  = r_has_byte;
        n_out_byte  = r_out_byte;
        n_out_pos   = r_out_pos;
        n_out_pend  = r_out_pend;
        n_out_ended = r_out_ended;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_q.valid) begin
                    if (do_store) begin
                        n_valid[wr_slot] = 1'b1;
                        n_pending        = r_pending + PEND_W'(1);
                    end
                    if (ent.sets_end && !r_end_known && (in_win || behind)) begin
                        n_end_known = 1'b1;
                        n_end       = ent.end_pos;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (deliverable) begin
                    n_state = S_EMIT;
                end else if (out_free) begin
                    // Nothing to deliver: one status-only result.
                    n_out_valid = 1'b1;
                    n_has_byte  = 1'b0;
                    n_out_byte  = '0;
                    n_out_pos   = r_head;
                    n_out_pend  = r_pending;
                    n_out_ended = r_end_known & ~head_end_diff[POS_W-1];
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_has_byte           = 1'b1;
                    n_out_byte           = rd_data;
                    n_out_pos            = r_head;
                    n_valid[r_head_slot] = 1'b0;
                    n_head               = head_inc;
                    n_head_slot          = next_slot;
                    if (r_pending != '0) begin
                        n_pending = r_pending - PEND_W'(1);
                    end
                    n_out_pend  = n_pending;
                    n_out_ended = r_end_known & ~inc_end_diff[POS_W-1];
                    n_out_last  = ~more;
                    n_state     = more ? S_CHECK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_head      <= '0;
            r_head_slot <= '0;
            r_pending   <= '0;
            r_end_known <= 1'b0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_head      <= n_head;
            r_head_slot <= n_head_slot;
            r_pending   <= n_pending;
            r_end_known <= n_end_known;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        r_has_byte  <= n_has_byte;
        r_out_byte  <= n_out_byte;
        r_out_pos   <= n_out_pos;
        r_out_pend  <= n_out_pend;
        r_out_ended <= n_out_ended;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.has_byte      = r_has_byte;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.out_position  = r_out_pos;
    assign o_out.pending_count = r_out_pend;
    assign o_out.stream_ended  = r_out_ended;
    assign o_out.last_of_run   = r_out_last;

    // The pending count never exceeds the window.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(WINDOW_SIZE))
        else $error("pending count beyond window size");

    // A byte is only emitted from a slot that is marked valid.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_valid[r_head_slot])
        else $error("emitting from an empty window slot");

    // A popped item always moves on to the drain check.
    a_pop_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_CHECK))
        else $error("popped item not checked");

    // A status-only result always closes its run.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_has_byte) |-> r_out_last)
        else $error("status result not marked last");

endmodule

[rtl/tcp_byte_stream_reassembler_unit.sv]
// An accepted item waits in a two-entry queue and is stored at the edge that takes it out;
// the check state that follows registers a status result, or reads the window so that the
// emit state after it registers a first byte.
// An item is drained before the next one leaves the queue: each delivered byte takes a check
// pass with the window RAM read and an emit pass, one byte per pass, and receiver stalls hold it.
// Reset: synchronous, active low; clears valid marks, head, counts and end latch, not the RAM.
module tcp_byte_stream_reassembler_unit import tcpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcpr_in_if.sink     i_in,
    tcpr_out_if.source  o_out
);

    t_q_head q_head;
    logic    q_pop;

    tcpr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (q_pop),
        .o_q     (q_head)
    );

    tcpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

[tb/tb_top.sv]
module tb_top;
    import tcpr_pkg::*;

    localparam t_pos HALF_RANGE = 32'h8000_0000;

    // One result item as the receiver sees it.
    typedef struct packed {
        logic  has_byte;
        t_byte out_byte;
        t_pos  out_position;
        t_pend pending_count;
        logic  stream_ended;
        logic  last_of_run;
    } t_delivery;

    // Tracks the reassembly window and holds the results still due from the block.
    class reasm_tracker;
        t_byte       held_byte [WINDOW_SIZE];
        bit          held_mark [WINDOW_SIZE];
        t_pos        head;
        t_slot       head_slot;
        int unsigned held_count;
        bit          end_seen;
        t_pos        end_at;
        t_delivery   due_results[$];
        int unsigned errors;
        int unsigned items_in;
        int unsigned bytes_out;
        int unsigned status_out;
        int unsigned longest_run;

        function new();
            foreach (held_mark[k]) held_mark[k] = 1'b0;
            head        = '0;
            head_slot   = '0;
            held_count  = 0;
            end_seen    = 1'b0;
            end_at      = '0;
            errors      = 0;
            items_in    = 0;
            bytes_out   = 0;
            status_out  = 0;
            longest_run = 0;
        endfunction

        // The stream is over once the head has reached or passed the end index.
        function bit stream_done();
            return end_seen && ((head - end_at) < HALF_RANGE);
        endfunction

        // The head byte can go out if it is held and the end has not been reached.
        function bit head_ready();
            return held_mark[head_slot] && !(end_seen && head == end_at);
        endfunction

        // Applies one accepted item and queues every result it causes.
        function void predict_delivery(t_command cmd, t_pos idx, t_byte val);
            t_pos        off;
            bit          in_win;
            bit          behind;
            bit          past_end;
            t_slot       slot;
            int unsigned run;
            t_delivery   d;
            off    = idx - head;
            in_win = off < WINDOW_SIZE;
            behind = off >= HALF_RANGE;
            run    = 0;
            items_in++;

            // Store the byte and latch the end where the position allows it.
            if (cmd != CMD_END) begin
                past_end = end_seen && ((idx - end_at) < HALF_RANGE);
                if (in_win && !past_end) begin
                    slot = t_slot'((int'(head_slot) + int'(off)) % WINDOW_SIZE);
                    if (!held_mark[slot]) begin
                        held_mark[slot] = 1'b1;
                        held_byte[slot] = val;
                        held_count++;
                    end
                end
                if (cmd == CMD_DATA_END && !end_seen && (in_win || behind)) begin
                    end_seen = 1'b1;
                    end_at   = idx + 1;
                end
            end else if (!end_seen && (in_win || behind)) begin
                end_seen = 1'b1;
                end_at   = idx;
            end

            // Deliver every contiguous byte at the head.
            while (head_ready()) begin
                d.has_byte     = 1'b1;
                d.out_byte     = held_byte[head_slot];
                d.out_position = head;
                held_mark[head_slot] = 1'b0;
                head_slot = t_slot'((int'(head_slot) + 1) % WINDOW_SIZE);
                head++;
                if (held_count > 0) begin
                    held_count--;
                end
                d.pending_count = t_pend'(held_count);
                d.stream_ended  = stream_done();
                d.last_of_run   = !head_ready();
                due_results.push_back(d);
                run++;
            end

            // With nothing delivered, the item still gives one status result.
            if (run == 0) begin
                d.has_byte      = 1'b0;
                d.out_byte      = '0;
                d.out_position  = head;
                d.pending_count = t_pend'(held_count);
                d.stream_ended  = stream_done();
                d.last_of_run   = 1'b1;
                due_results.push_back(d);
                status_out++;
            end else begin
                bytes_out += run;
                if (run > longest_run) begin
                    longest_run = run;
                end
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
        endtask

        // Compares one result with the oldest one still due.
        task check_result(t_delivery got);
            t_delivery want;
            if (due_results.size() == 0) begin
                report($sformatf("result with nothing due: has_byte %0b byte %02h position %0d",
                                 got.has_byte, got.out_byte, got.out_position));
                return;
            end
            want = due_results.pop_front();
            if (got.has_byte !== want.has_byte) begin
                report($sformatf("has_byte %0b, want %0b at position %0d",
                                 got.has_byte, want.has_byte, want.out_position));
            end
            if (got.out_byte !== want.out_byte) begin
                report($sformatf("out_byte %02h, want %02h at position %0d",
                                 got.out_byte, want.out_byte, want.out_position));
            end
            if (got.out_position !== want.out_position) begin
                report($sformatf("out_position %0d, want %0d",
                                 got.out_position, want.out_position));
            end
            if (got.pending_count !== want.pending_count) begin
                report($sformatf("pending_count %0d, want %0d at position %0d",
                                 got.pending_count, want.pending_count, want.out_position));
            end
            if (got.stream_ended !== want.stream_ended) begin
                report($sformatf("stream_ended %0b, want %0b at position %0d",
                                 got.stream_ended, want.stream_ended, want.out_position));
            end
            if (got.last_of_run !== want.last_of_run) begin
                report($sformatf("last_of_run %0b, want %0b at position %0d",
                                 got.last_of_run, want.last_of_run, want.out_position));
            end
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;
    int unsigned  stored_count;
    int unsigned  close_mode;
    string        close_names [4] = '{"end marker ahead of the head",
                                      "last byte ahead of the head",
                                      "end marker at or behind the head",
                                      "last byte behind the head"};
    reasm_tracker tracker = new();

    tcpr_in_if  in_if ();
    tcpr_out_if out_if ();

    tcp_byte_stream_reassembler_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: ready changes on the falling edge, results are taken on the rising edge.
    always @(negedge clk) begin
        out_if.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : take_result
        t_delivery got;
        if (rst_n && out_if.valid && out_if.ready) begin
            got.has_byte      = out_if.has_byte;
            got.out_byte      = out_if.out_byte;
            got.out_position  = out_if.out_position;
            got.pending_count = out_if.pending_count;
            got.stream_ended  = out_if.stream_ended;
            got.last_of_run   = out_if.last_of_run;
            tracker.check_result(got);
        end
    end

    // Picks how often each side holds back.
    task automatic set_idle(int unsigned mode);
        case (mode)
            1: begin
                send_idle_pct  = 47;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 47;
            end
            3: begin
                send_idle_pct  = 7;
                recv_stall_pct = 7;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Offers one item, called and returning at a falling edge; valid stays high on return.
    task automatic send_item(t_command cmd, t_pos idx, t_byte val);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.command      <= cmd;
        in_if.stream_index <= idx;
        in_if.byte_value   <= val;
        @(posedge clk);
        while (!in_if.ready) begin
            @(posedge clk);
        end
        tracker.predict_delivery(cmd, idx, val);
        @(negedge clk);
    endtask

    // Holds the sender back until every result due has come out.
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (tracker.due_results.size() != 0) begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // Off-pattern items: duplicates, bytes behind or beyond, end commands that cannot latch.
    task automatic send_noise();
        t_pos     idx;
        t_command cmd;
        cmd = CMD_DATA;
        case ($urandom_range(0, 4))
            0: idx = tracker.head + $urandom_range(0, WINDOW_SIZE - 1);
            1: idx = tracker.head - $urandom_range(1, 300);
            2: idx = tracker.head + WINDOW_SIZE + $urandom_range(0, 300);
            3: idx = $urandom;
            default: begin
                cmd = ($urandom_range(0, 1) == 0) ? CMD_END : CMD_DATA_END;
                idx = tracker.head + WINDOW_SIZE + $urandom_range(0, 32'h7FFF_FF00);
            end
        endcase
        send_item(cmd, idx, t_byte'($urandom));
    endtask

    // Sends the next len bytes from the head in shuffled order, with noise mixed in.
    task automatic send_segment(int unsigned len, bit head_last);
        t_pos        spot [WINDOW_SIZE];
        t_pos        base;
        t_pos        tmp;
        int unsigned first;
        int unsigned k;
        int unsigned j;
        base  = tracker.head;
        first = head_last ? 1 : 0;
        for (k = 0; k < len; k++) begin
            spot[k] = base + k;
        end
        for (k = len - 1; k > first; k--) begin
            j       = $urandom_range(first, k);
            tmp     = spot[k];
            spot[k] = spot[j];
            spot[j] = tmp;
        end
        // Holding the head byte back makes the whole segment drain in one run.
        if (head_last) begin
            tmp            = spot[0];
            spot[0]        = spot[len - 1];
            spot[len - 1]  = tmp;
        end
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 15) begin
                send_noise();
            end
            send_item(($urandom_range(0, 9) == 0) ? CMD_RSVD : CMD_DATA, spot[k],
                      t_byte'($urandom));
            stored_count++;
        end
    endtask

    // Latches the end of the stream in one of four ways, then pokes the ended stream.
    task automatic close_stream();
        t_pos        order [16];
        t_pos        base;
        t_pos        tmp;
        int unsigned k;
        int unsigned j;
        int unsigned m;
        base       = tracker.head;
        k          = $urandom_range(2, 8);
        close_mode = $urandom_range(0, 3);
        if (close_mode < 2) begin
            // Bytes on both sides of the coming end, with the head byte missing.
            for (j = 0; j < k + 3; j++) begin
                order[j] = base + 1 + j;
            end
            for (j = k + 2; j > 0; j--) begin
                m        = $urandom_range(0, j);
                tmp      = order[j];
                order[j] = order[m];
                order[m] = tmp;
            end
            for (j = 0; j < k + 3; j++) begin
                send_item(CMD_DATA, order[j], t_byte'($urandom));
            end
            if (close_mode == 0) begin
                send_item(CMD_END, base + k, t_byte'($urandom));
            end else begin
                send_item(CMD_DATA_END, base + k - 1, t_byte'($urandom));
            end
            // A new byte past the end is dropped; the head byte drains up to the end only.
            send_item(CMD_DATA, base + k + 5, t_byte'($urandom));
            send_item(CMD_DATA, base, t_byte'($urandom));
        end else if (close_mode == 2) begin
            send_item(CMD_END, base - $urandom_range(0, 5), t_byte'($urandom));
            send_item(CMD_DATA, base, t_byte'($urandom));
        end else begin
            send_item(CMD_DATA_END, base - $urandom_range(1, 5), t_byte'($urandom));
            send_item(CMD_DATA, base + 1, t_byte'($urandom));
        end
        // Later end commands are ignored and nothing more is delivered.
        for (j = 0; j < 10; j++) begin
            send_item(t_command'($urandom_range(0, 3)), tracker.head - 8 + $urandom_range(0, 80),
                      t_byte'($urandom));
        end
    endtask

    initial begin : stimulus
        int unsigned seg;
        rst_n               = 1'b0;
        in_if.valid         = 1'b0;
        in_if.command       = CMD_DATA;
        in_if.stream_index  = '0;
        in_if.byte_value    = '0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        stored_count        = 0;
        close_mode          = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: out-of-order start, byte extremes, the reserved code, window edges.
        send_item(CMD_DATA, 32'd5, 8'hFF);
        send_item(CMD_DATA, 32'd0, 8'h00);
        send_item(CMD_RSVD, 32'd1, 8'hA5);
        send_item(CMD_DATA, 32'd5, 8'h11);
        send_item(CMD_DATA, 32'd0, 8'h22);
        send_item(CMD_DATA, 32'hFFFF_FFFF, 8'h33);
        send_item(CMD_DATA, tracker.head + WINDOW_SIZE, 8'h44);
        send_item(CMD_DATA, tracker.head + WINDOW_SIZE - 1, 8'h5A);
        send_item(CMD_DATA, tracker.head + HALF_RANGE, 8'h66);
        send_item(CMD_DATA, tracker.head + HALF_RANGE - 1, 8'h77);
        // End commands beyond the window neither store nor latch.
        send_item(CMD_DATA_END, tracker.head + WINDOW_SIZE, 8'h88);
        send_item(CMD_END, tracker.head + WINDOW_SIZE, 8'h00);
        send_item(CMD_END, 32'h5555_5555, 8'hC3);
        send_item(CMD_DATA_END, 32'h7FFF_FFFF, 8'h3C);
        // Fill the gaps so the stored bytes drain.
        send_item(CMD_DATA, 32'd3, 8'h01);
        send_item(CMD_DATA, 32'd2, 8'h80);
        send_item(CMD_DATA, 32'd4, 8'h7F);
        wait_for_results();

        // Random segments: one full window first, then mostly short ones.
        seg = 0;
        set_idle(0);
        send_segment(WINDOW_SIZE, 1'b1);
        while (stored_count < 200) begin
            seg++;
            set_idle(seg % 4);
            send_segment(($urandom_range(0, 3) == 0) ? $urandom_range(30, WINDOW_SIZE)
                                                     : $urandom_range(1, 12),
                         $urandom_range(0, 3) == 0);
        end
        wait_for_results();

        set_idle(3);
        close_stream();
        wait_for_results();
        repeat (20) @(negedge clk);
        if (tracker.due_results.size() != 0) begin
            tracker.report($sformatf("%0d results never came out", tracker.due_results.size()));
        end

        $display("Covered %0d items in, %0d bytes assembled, %0d status-only results, longest run %0d.",
                 tracker.items_in, tracker.bytes_out, tracker.status_out, tracker.longest_run);
        $display("Stream closed by %s; final head %0d with %0d bytes left stored.",
                 close_names[close_mode], tracker.head, tracker.held_count);
        if (tracker.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #(12 * 400000);
        $display("Timeout with %0d results still due.", tracker.due_results.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
